/* rtl/nearest_neighbor_frame_scaler_top_defines.svh */
// Assertion macros shared by the checker of the frame scaler.
`ifndef NEAREST_NEIGHBOR_FRAME_SCALER_TOP_DEFINES_SVH
`define NEAREST_NEIGHBOR_FRAME_SCALER_TOP_DEFINES_SVH

// Property checked only while reset is released.
`define NNFS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Property checked at every edge, reset included.
`define NNFS_ASSERT_ALL(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

/* rtl/nnfs_pkg.sv */
// ----------------------------------------------------------------------------
// nnfs_pkg
// Types, constants and colour helpers of the nearest-neighbour frame scaler.
// ----------------------------------------------------------------------------
package nnfs_pkg;

    localparam int COORD_W  = 11;
    localparam int PIX_W    = 16;
    localparam int CH_W     = 8;
    localparam int SRCCFG_W = 9;
    localparam int FULL_W   = 12;
    localparam int SUM_W    = 12;
    localparam int SIZE_W   = 11;
    localparam int NUM_W    = SUM_W + SIZE_W;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 12;

    localparam logic [PIX_W-1:0] DIM_MASK = 16'hF7DE;

    // Register indexes of the configuration port.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SRC_WIDTH   = 3'd0,
        CFG_SRC_HEIGHT  = 3'd1,
        CFG_FULL_WIDTH  = 3'd2,
        CFG_FULL_HEIGHT = 3'd3,
        CFG_CROP_LEFT   = 3'd4,
        CFG_CROP_TOP    = 3'd5,
        CFG_SCANLINE    = 3'd6
    } t_cfg_idx;

    typedef struct packed {
        logic [SRCCFG_W-1:0] src_w;
        logic [SRCCFG_W-1:0] src_h;
        logic [FULL_W-1:0]   full_w;
        logic [FULL_W-1:0]   full_h;
        logic [COORD_W-1:0]  crop_l;
        logic [COORD_W-1:0]  crop_t;
        logic                dim;
    } t_cfg;

    // Control and payload that travel with each item down the pipeline.
    typedef struct packed {
        logic               vld;
        logic               rd;
        logic               dim;
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] row;
        logic [PIX_W-1:0]   sample;
    } t_ctl;

    // Expand a 5-bit channel to 8 bits: v*255/31 = 8v + floor(7v/31).
    function automatic logic [CH_W-1:0] exp5(input logic [4:0] v);
        logic [2:0] f;
        begin
            if (v >= 5'd31)      f = 3'd7;
            else if (v >= 5'd27) f = 3'd6;
            else if (v >= 5'd23) f = 3'd5;
            else if (v >= 5'd18) f = 3'd4;
            else if (v >= 5'd14) f = 3'd3;
            else if (v >= 5'd9)  f = 3'd2;
            else if (v >= 5'd5)  f = 3'd1;
            else                 f = 3'd0;
            exp5 = {v, f};
        end
    endfunction

    // Expand a 6-bit channel to 8 bits: v*255/63 = 4v + floor(v/21).
    function automatic logic [CH_W-1:0] exp6(input logic [5:0] v);
        logic [1:0] f;
        begin
            if (v >= 6'd63)      f = 2'd3;
            else if (v >= 6'd42) f = 2'd2;
            else if (v >= 6'd21) f = 2'd1;
            else                 f = 2'd0;
            exp6 = {v, f};
        end
    endfunction

endpackage

/* rtl/nnfs_map.sv */
// ----------------------------------------------------------------------------
// nnfs_map
// Input register and axis set-up: crop, clamped sizes, products and saturation.
// ----------------------------------------------------------------------------
module nnfs_map #(
    parameter int SRC_MAX_W = 256,
    parameter int SRC_MAX_H = 256,
    parameter int QB        = 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_acc,
    input  logic                          i_mode,
    input  logic [nnfs_pkg::COORD_W-1:0]  i_col,
    input  logic [nnfs_pkg::COORD_W-1:0]  i_row,
    input  logic [nnfs_pkg::PIX_W-1:0]    i_sample,
    input  nnfs_pkg::t_cfg                i_cfg,
    output nnfs_pkg::t_ctl                o_ctl,
    output logic [nnfs_pkg::NUM_W-1:0]    o_numx,
    output logic [nnfs_pkg::NUM_W-1:0]    o_numy,
    output logic [nnfs_pkg::FULL_W-1:0]   o_fx,
    output logic [nnfs_pkg::FULL_W-1:0]   o_fy,
    output logic                          o_satx,
    output logic                          o_saty,
    output logic [QB-1:0]                 o_smx,
    output logic [QB-1:0]                 o_smy
);
    import nnfs_pkg::*;

    t_ctl              r_c1, n_c1;
    t_ctl              r_c2;
    logic [NUM_W-1:0]  r_numx, r_numy;
    logic [FULL_W-1:0] r_fx, r_fy;
    logic              r_satx, r_saty;
    logic [QB-1:0]     r_smx, r_smy;

    logic [FULL_W-1:0] fx, fy, cx, cy;
    logic [SIZE_W-1:0] sx, sy;
    logic [SUM_W-1:0]  sumx, sumy;

    // Input register: the item is captured as it is accepted.
    always_comb begin
        n_c1        = '0;
        n_c1.vld    = i_acc;
        n_c1.rd     = i_mode;
        n_c1.dim    = i_cfg.dim & i_row[0];
        n_c1.col    = i_col;
        n_c1.row    = i_row;
        n_c1.sample = i_sample;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c1.vld <= 1'b0;
        end else begin
            r_c1.vld <= n_c1.vld;
        end
        r_c1.rd     <= n_c1.rd;
        r_c1.dim    <= n_c1.dim;
        r_c1.col    <= n_c1.col;
        r_c1.row    <= n_c1.row;
        r_c1.sample <= n_c1.sample;
    end

    // Effective sizes and crops of both axes.
    always_comb begin
        fx = (i_cfg.full_w == '0) ? FULL_W'(1) : i_cfg.full_w;
        fy = (i_cfg.full_h == '0) ? FULL_W'(1) : i_cfg.full_h;
        if (i_cfg.src_w == '0)
            sx = SIZE_W'(1);
        else if (SIZE_W'(i_cfg.src_w) > SIZE_W'(SRC_MAX_W))
            sx = SIZE_W'(SRC_MAX_W);
        else
            sx = SIZE_W'(i_cfg.src_w);
        if (i_cfg.src_h == '0)
            sy = SIZE_W'(1);
        else if (SIZE_W'(i_cfg.src_h) > SIZE_W'(SRC_MAX_H))
            sy = SIZE_W'(SRC_MAX_H);
        else
            sy = SIZE_W'(i_cfg.src_h);
        cx   = (FULL_W'(i_cfg.crop_l) >= fx) ? '0 : FULL_W'(i_cfg.crop_l);
        cy   = (FULL_W'(i_cfg.crop_t) >= fy) ? '0 : FULL_W'(i_cfg.crop_t);
        sumx = SUM_W'(r_c1.col) + SUM_W'(cx);
        sumy = SUM_W'(r_c1.row) + SUM_W'(cy);
    end

    // Second register: the products to divide and the saturation decision.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c2.vld <= 1'b0;
        end else begin
            r_c2.vld <= r_c1.vld;
        end
        r_c2.rd     <= r_c1.rd;
        r_c2.dim    <= r_c1.dim;
        r_c2.col    <= r_c1.col;
        r_c2.row    <= r_c1.row;
        r_c2.sample <= r_c1.sample;
        r_numx      <= NUM_W'(sumx) * NUM_W'(sx);
        r_numy      <= NUM_W'(sumy) * NUM_W'(sy);
        r_fx        <= fx;
        r_fy        <= fy;
        r_satx      <= (sumx >= fx);
        r_saty      <= (sumy >= fy);
        r_smx       <= QB'(sx - SIZE_W'(1));
        r_smy       <= QB'(sy - SIZE_W'(1));
    end

    assign o_ctl  = r_c2;
    assign o_numx = r_numx;
    assign o_numy = r_numy;
    assign o_fx   = r_fx;
    assign o_fy   = r_fy;
    assign o_satx = r_satx;
    assign o_saty = r_saty;
    assign o_smx  = r_smx;
    assign o_smy  = r_smy;

endmodule

/* rtl/nnfs_div.sv */
// ----------------------------------------------------------------------------
// nnfs_div
// Pipelined restoring divider for both axes, one quotient bit per stage.
// ----------------------------------------------------------------------------
module nnfs_div #(
    parameter int QB = 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  nnfs_pkg::t_ctl                i_ctl,
    input  logic [nnfs_pkg::NUM_W-1:0]    i_numx,
    input  logic [nnfs_pkg::NUM_W-1:0]    i_numy,
    input  logic [nnfs_pkg::FULL_W-1:0]   i_fx,
    input  logic [nnfs_pkg::FULL_W-1:0]   i_fy,
    input  logic                          i_satx,
    input  logic                          i_saty,
    input  logic [QB-1:0]                 i_smx,
    input  logic [QB-1:0]                 i_smy,
    output nnfs_pkg::t_ctl                o_ctl,
    output logic [QB-1:0]                 o_sx,
    output logic [QB-1:0]                 o_sy
);
    import nnfs_pkg::*;

    t_ctl              r_ctl  [0:QB];
    logic [NUM_W-1:0]  r_remx [0:QB];
    logic [NUM_W-1:0]  r_remy [0:QB];
    logic [FULL_W-1:0] r_fx   [0:QB];
    logic [FULL_W-1:0] r_fy   [0:QB];
    logic [QB-1:0]     r_qx   [0:QB];
    logic [QB-1:0]     r_qy   [0:QB];
    logic              r_satx [0:QB];
    logic              r_saty [0:QB];
    logic [QB-1:0]     r_smx  [0:QB];
    logic [QB-1:0]     r_smy  [0:QB];

    // Stage zero is the set-up register of the map stage.
    always_comb begin
        r_ctl[0]  = i_ctl;
        r_remx[0] = i_numx;
        r_remy[0] = i_numy;
        r_fx[0]   = i_fx;
        r_fy[0]   = i_fy;
        r_qx[0]   = '0;
        r_qy[0]   = '0;
        r_satx[0] = i_satx;
        r_saty[0] = i_saty;
        r_smx[0]  = i_smx;
        r_smy[0]  = i_smy;
    end

    // Each stage tries the divisor shifted to its own quotient bit.
    for (genvar k = 0; k < QB; k++) begin : g_stage
        localparam int BIT = QB - 1 - k;
        logic [NUM_W-1:0] dx, dy;
        logic             gx, gy;

        always_comb begin
            dx = NUM_W'(r_fx[k]) << BIT;
            dy = NUM_W'(r_fy[k]) << BIT;
            gx = (r_remx[k] >= dx);
            gy = (r_remy[k] >= dy);
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_ctl[k+1].vld <= 1'b0;
            end else begin
                r_ctl[k+1].vld <= r_ctl[k].vld;
            end
            r_ctl[k+1].rd     <= r_ctl[k].rd;
            r_ctl[k+1].dim    <= r_ctl[k].dim;
            r_ctl[k+1].col    <= r_ctl[k].col;
            r_ctl[k+1].row    <= r_ctl[k].row;
            r_ctl[k+1].sample <= r_ctl[k].sample;
            r_remx[k+1]       <= gx ? (r_remx[k] - dx) : r_remx[k];
            r_remy[k+1]       <= gy ? (r_remy[k] - dy) : r_remy[k];
            r_qx[k+1]         <= r_qx[k] | (QB'(gx) << BIT);
            r_qy[k+1]         <= r_qy[k] | (QB'(gy) << BIT);
            r_fx[k+1]         <= r_fx[k];
            r_fy[k+1]         <= r_fy[k];
            r_satx[k+1]       <= r_satx[k];
            r_saty[k+1]       <= r_saty[k];
            r_smx[k+1]        <= r_smx[k];
            r_smy[k+1]        <= r_smy[k];
        end
    end

    // A destination past the full size maps to the last source column or row.
    assign o_ctl = r_ctl[QB];
    assign o_sx  = r_satx[QB] ? r_smx[QB] : r_qx[QB];
    assign o_sy  = r_saty[QB] ? r_smy[QB] : r_qy[QB];

endmodule

/* rtl/nnfs_frame.sv */
// ----------------------------------------------------------------------------
// nnfs_frame
// Source frame store: address register and single-port memory access.
// ----------------------------------------------------------------------------
module nnfs_frame #(
    parameter int SRC_MAX_W = 256,
    parameter int SRC_MAX_H = 256,
    parameter int QB        = 8
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  nnfs_pkg::t_ctl              i_ctl,
    input  logic [QB-1:0]               i_sx,
    input  logic [QB-1:0]               i_sy,
    output logic                        o_vld,
    output logic                        o_dim,
    output logic [nnfs_pkg::PIX_W-1:0]  o_pix
);
    import nnfs_pkg::*;

    localparam int DEPTH = SRC_MAX_W * SRC_MAX_H;
    localparam int AW    = $clog2(DEPTH);

    logic [PIX_W-1:0] mem [0:DEPTH-1];

    logic [AW-1:0]    r_addr, n_addr;
    logic             r_we, n_we;
    logic             r_rv, r_dim;
    logic [PIX_W-1:0] r_wdata;
    logic             r_ov, r_odim;
    logic [PIX_W-1:0] r_rdata;

    // Reads use the mapped position, writes the given one if it is in the frame.
    always_comb begin
        if (i_ctl.rd)
            n_addr = AW'(AW'(i_sy) * AW'(SRC_MAX_W)) + AW'(i_sx);
        else
            n_addr = AW'(AW'(i_ctl.row) * AW'(SRC_MAX_W)) + AW'(i_ctl.col);
        n_we = i_ctl.vld && !i_ctl.rd
               && (SIZE_W'(i_ctl.col) < SIZE_W'(SRC_MAX_W))
               && (SIZE_W'(i_ctl.row) < SIZE_W'(SRC_MAX_H));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_we <= 1'b0;
            r_rv <= 1'b0;
        end else begin
            r_we <= n_we;
            r_rv <= i_ctl.vld && i_ctl.rd;
        end
        r_addr  <= n_addr;
        r_dim   <= i_ctl.dim;
        r_wdata <= i_ctl.sample;
    end

    // Memory port: items reach it in order, so every read sees earlier writes.
    always_ff @(posedge i_clk) begin
        if (r_we) begin
            mem[r_addr] <= r_wdata;
        end
        r_rdata <= mem[r_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else begin
            r_ov <= r_rv;
        end
        r_odim <= r_dim;
    end

    assign o_vld = r_ov;
    assign o_dim = r_odim;
    assign o_pix = r_rdata;

endmodule

/* rtl/nnfs_shade.sv */
// ----------------------------------------------------------------------------
// nnfs_shade
// Output stage: scanline dimming and expansion of the channels to 8 bits.
// ----------------------------------------------------------------------------
module nnfs_shade (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_vld,
    input  logic                        i_dim,
    input  logic [nnfs_pkg::PIX_W-1:0]  i_pix,
    output logic                        o_valid,
    output logic [nnfs_pkg::PIX_W-1:0]  o_pixel565,
    output logic [nnfs_pkg::CH_W-1:0]   o_red,
    output logic [nnfs_pkg::CH_W-1:0]   o_green,
    output logic [nnfs_pkg::CH_W-1:0]   o_blue
);
    import nnfs_pkg::*;

    logic [PIX_W-1:0] pix;
    logic             r_valid;
    logic [PIX_W-1:0] r_pix;
    logic [CH_W-1:0]  r_red, r_green, r_blue;

    // Odd rows in scanline mode lose one bit of each channel.
    always_comb begin
        pix = i_dim ? ((i_pix & DIM_MASK) >> 1) : i_pix;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_vld;
        end
        r_pix   <= pix;
        r_red   <= exp5(pix[15:11]);
        r_green <= exp6(pix[10:5]);
        r_blue  <= exp5(pix[4:0]);
    end

    assign o_valid    = r_valid;
    assign o_pixel565 = r_pix;
    assign o_red      = r_red;
    assign o_green    = r_green;
    assign o_blue     = r_blue;

endmodule

/* rtl/nearest_neighbor_frame_scaler_top.sv */
// A read item passes the input, set-up, divider, frame address, memory read and
// output registers to o_valid. Throughput: one item per clock; the divider has
// one stage per quotient bit, QB being log2 of the larger source side. Writes
// take the same path to the single memory port and give no result. Synchronous
// active-low reset clears the pipeline and loads register defaults; the frame
// contents are not cleared. busy stays low, as nothing ever stalls.
// ----------------------------------------------------------------------------
// nearest_neighbor_frame_scaler_top
// Nearest-neighbour scaler over a stored RGB565 source frame.
// ----------------------------------------------------------------------------
module nearest_neighbor_frame_scaler_top #(
    parameter int SRC_MAX_W = 256,
    parameter int SRC_MAX_H = 256
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic                            i_mode,
    input  logic [nnfs_pkg::COORD_W-1:0]    i_col,
    input  logic [nnfs_pkg::COORD_W-1:0]    i_row,
    input  logic [nnfs_pkg::PIX_W-1:0]      i_sample,
    input  logic                            i_cfg_we,
    input  logic [nnfs_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [nnfs_pkg::CFG_DAT_W-1:0]  i_cfg_wdata,
    output logic                            o_valid,
    output logic [nnfs_pkg::PIX_W-1:0]      o_pixel565,
    output logic [nnfs_pkg::CH_W-1:0]       o_red,
    output logic [nnfs_pkg::CH_W-1:0]       o_green,
    output logic [nnfs_pkg::CH_W-1:0]       o_blue
);
    import nnfs_pkg::*;

    localparam int QB = $clog2((SRC_MAX_W > SRC_MAX_H) ? SRC_MAX_W : SRC_MAX_H);

    t_cfg              r_cfg;
    t_ctl              map_ctl, div_ctl;
    logic [NUM_W-1:0]  numx, numy;
    logic [FULL_W-1:0] fx, fy;
    logic              satx, saty;
    logic [QB-1:0]     smx, smy, sx, sy;
    logic              fr_vld, fr_dim;
    logic [PIX_W-1:0]  fr_pix;

    assign busy = 1'b0;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.src_w  <= SRCCFG_W'(256);
            r_cfg.src_h  <= SRCCFG_W'(192);
            r_cfg.full_w <= FULL_W'(256);
            r_cfg.full_h <= FULL_W'(192);
            r_cfg.crop_l <= '0;
            r_cfg.crop_t <= '0;
            r_cfg.dim    <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_SRC_WIDTH:   r_cfg.src_w  <= i_cfg_wdata[SRCCFG_W-1:0];
                CFG_SRC_HEIGHT:  r_cfg.src_h  <= i_cfg_wdata[SRCCFG_W-1:0];
                CFG_FULL_WIDTH:  r_cfg.full_w <= i_cfg_wdata[FULL_W-1:0];
                CFG_FULL_HEIGHT: r_cfg.full_h <= i_cfg_wdata[FULL_W-1:0];
                CFG_CROP_LEFT:   r_cfg.crop_l <= i_cfg_wdata[COORD_W-1:0];
                CFG_CROP_TOP:    r_cfg.crop_t <= i_cfg_wdata[COORD_W-1:0];
                CFG_SCANLINE:    r_cfg.dim    <= i_cfg_wdata[0];
                default: begin
                end
            endcase
        end
    end

    nnfs_map #(.SRC_MAX_W(SRC_MAX_W), .SRC_MAX_H(SRC_MAX_H), .QB(QB)) u_map (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_acc    (start && !busy),
        .i_mode   (i_mode),
        .i_col    (i_col),
        .i_row    (i_row),
        .i_sample (i_sample),
        .i_cfg    (r_cfg),
        .o_ctl    (map_ctl),
        .o_numx   (numx),
        .o_numy   (numy),
        .o_fx     (fx),
        .o_fy     (fy),
        .o_satx   (satx),
        .o_saty   (saty),
        .o_smx    (smx),
        .o_smy    (smy)
    );

    nnfs_div #(.QB(QB)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (map_ctl),
        .i_numx  (numx),
        .i_numy  (numy),
        .i_fx    (fx),
        .i_fy    (fy),
        .i_satx  (satx),
        .i_saty  (saty),
        .i_smx   (smx),
        .i_smy   (smy),
        .o_ctl   (div_ctl),
        .o_sx    (sx),
        .o_sy    (sy)
    );

    nnfs_frame #(.SRC_MAX_W(SRC_MAX_W), .SRC_MAX_H(SRC_MAX_H), .QB(QB)) u_frame (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (div_ctl),
        .i_sx    (sx),
        .i_sy    (sy),
        .o_vld   (fr_vld),
        .o_dim   (fr_dim),
        .o_pix   (fr_pix)
    );

    nnfs_shade u_shade (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_vld      (fr_vld),
        .i_dim      (fr_dim),
        .i_pix      (fr_pix),
        .o_valid    (o_valid),
        .o_pixel565 (o_pixel565),
        .o_red      (o_red),
        .o_green    (o_green),
        .o_blue     (o_blue)
    );

endmodule

/* rtl/nnfs_checker.sv */
// ----------------------------------------------------------------------------
// nnfs_checker
// Port-level checks of the frame scaler, bound to the top level.
// ----------------------------------------------------------------------------
`include "nearest_neighbor_frame_scaler_top_defines.svh"

module nnfs_checker #(
    parameter int SRC_MAX_W = 256,
    parameter int SRC_MAX_H = 256
) (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            start,
    input logic                            busy,
    input logic                            i_mode,
    input logic                            o_valid,
    input logic [nnfs_pkg::PIX_W-1:0]      o_pixel565,
    input logic [nnfs_pkg::CH_W-1:0]       o_red,
    input logic [nnfs_pkg::CH_W-1:0]       o_green,
    input logic [nnfs_pkg::CH_W-1:0]       o_blue
);
    localparam int QB  = $clog2((SRC_MAX_W > SRC_MAX_H) ? SRC_MAX_W : SRC_MAX_H);
    localparam int LAT = QB + 5;

    logic rd_acc;
    logic chan_ok;

    // A read item is accepted at this edge.
    assign rd_acc = start && !busy && i_mode;

    // The expanded channels carry the RGB565 channels in their upper bits.
    assign chan_ok = (o_red[7:3] == o_pixel565[15:11])
                     && (o_green[7:2] == o_pixel565[10:5])
                     && (o_blue[7:3] == o_pixel565[4:0]);

    // The pipeline never holds an item off.
    `NNFS_ASSERT(a_never_busy, !busy, "busy raised")

    // Reset empties the pipeline.
    `NNFS_ASSERT_ALL(a_rst_clears, !i_rst_n |=> !o_valid, "result strobe after reset")

    // Every result comes from a read item accepted a fixed time earlier.
    `NNFS_ASSERT(a_from_read, o_valid |-> $past(rd_acc, LAT), "unrequested result")

    // Each result shows consistent RGB565 and 8-bit channels.
    `NNFS_ASSERT(a_expand, o_valid |-> chan_ok, "channel expansion mismatch")

endmodule

bind nearest_neighbor_frame_scaler_top nnfs_checker #(
    .SRC_MAX_W(SRC_MAX_W),
    .SRC_MAX_H(SRC_MAX_H)
) u_nnfs_checker (.*);
